// File: rtl/fcbp_pkg.sv
`default_nettype none

package fcbp_pkg;

  // Payload bytes held for the head and digit fields (3 to 28).
  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned StoreIdxW    = $clog2(PayloadBytes);
  localparam int unsigned HeadBytes    = 8;

  localparam logic [7:0]  CharCr   = 8'd13;
  localparam logic [7:0]  CharLf   = 8'd10;
  localparam logic [7:0]  CharZero = 8'h30;
  localparam logic [7:0]  CountMax = 8'hFF;
  localparam logic [15:0] BadDigit = 16'hFFFF;

  // Command byte values
  localparam logic [7:0] CmdFirst    = 8'd6;
  localparam logic [7:0] CmdLast     = 8'd21;
  localparam logic [7:0] CmdSleepClr = 8'd13;
  localparam logic [7:0] CmdDebug    = 8'd14;
  localparam logic [7:0] CmdSleep    = 8'd15;
  localparam logic [7:0] CmdPower    = 8'd16;
  localparam logic [7:0] CmdCoef     = 8'd19;

  typedef enum logic [3:0] {
    PhHunt    = 4'b0001,
    PhLf      = 4'b0010,
    PhPayload = 4'b0100,
    PhCmd     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [3:0]  command_code;
    logic [7:0]  payload_len;
    logic        payload_overflow;
    logic [63:0] payload_head;
    logic [15:0] digit_value;
    logic [7:0]  coef_select;
    logic        debug_on;
    logic        sleep_on;
    logic        power_on;
  } res_t;

  // Leading payload bytes plus length, fed to the digit converter.
  typedef struct packed {
    logic [7:0]  len;
    logic [23:0] lead;
  } digit_src_t;

endpackage

`default_nettype wire

// File: rtl/fcbp_rx_if.sv
`default_nettype none

interface fcbp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/fcbp_res_if.sv
`default_nettype none

interface fcbp_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command_code;
  logic [7:0]  payload_len;
  logic        payload_overflow;
  logic [63:0] payload_head;
  logic [15:0] digit_value;
  logic [7:0]  coef_select;
  logic        debug_on;
  logic        sleep_on;
  logic        power_on;

  modport source (
    output valid, output command_code, output payload_len, output payload_overflow,
    output payload_head, output digit_value, output coef_select, output debug_on,
    output sleep_on, output power_on, input ready
  );
  modport sink (
    input valid, input command_code, input payload_len, input payload_overflow,
    input payload_head, input digit_value, input coef_select, input debug_on,
    input sleep_on, input power_on, output ready
  );
endinterface

`default_nettype wire

// File: rtl/fcbp_digit_conv.sv
`default_nettype none

// Three ASCII digits to a binary value; BadDigit if any is missing or not 0-9.
module fcbp_digit_conv (
  input  fcbp_pkg::digit_src_t src_i,
  output logic [15:0]          digit_value_o
);

  logic [7:0] d0, d1, d2;
  logic       bad;

  always_comb begin
    d0  = src_i.lead[7:0]   ^ fcbp_pkg::CharZero;
    d1  = src_i.lead[15:8]  ^ fcbp_pkg::CharZero;
    d2  = src_i.lead[23:16] ^ fcbp_pkg::CharZero;
    bad = (d0 > 8'd9) || (d1 > 8'd9) || (d2 > 8'd9) || (src_i.len < 8'd3);
    if (bad) begin
      digit_value_o = fcbp_pkg::BadDigit;
    end else begin
      digit_value_o = 16'(d0) * 16'd100 + 16'(d1) * 16'd10 + 16'(d2);
    end
  end

endmodule

`default_nettype wire

// File: rtl/framed_command_byte_parser_unit.sv
`default_nettype none

// Framed command byte parser. Takes one received byte per transaction on rx_i
// and hunts for a CR LF start; the bytes after it up to the next CR are the
// payload, and the byte after that CR is the command. Command bytes 6 to 21
// give one transaction on res_o (code renumbered 0 to 15) carrying the payload
// length (saturating at 255), an overflow flag when more than PayloadBytes
// bytes came, the first eight stored bytes, the three-digit decimal value of
// the payload (65535 if not three valid digits) and the control bits as they
// stand after the command. Any other command byte ends the frame silently.
// Rate: one byte per clock while rx_i.ready is high. Parse state updates on
// the accepting edge; the result sits in a one-deep output register from the
// cycle after its command byte. rx_i.ready is low only while that register
// holds a result the sink is not taking in the same cycle.
module framed_command_byte_parser_unit (
  input  wire             clk_i,
  input  wire             rst_ni,
  fcbp_rx_if.sink         rx_i,
  fcbp_res_if.source      res_o
);

  fcbp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic        overflow_q, overflow_d;
  logic [7:0]  store_q [fcbp_pkg::PayloadBytes];
  logic [7:0]  coef_q, coef_d;
  logic        debug_q, debug_d;
  logic        sleep_q, sleep_d;
  logic        power_q, power_d;
  logic        out_valid_q, out_valid_d;
  fcbp_pkg::res_t res_q, res_d;

  logic        in_acc;
  logic [7:0]  rx_byte;
  logic        cmd_hit;
  logic        fire;
  logic        store_wr;
  logic [63:0] head;
  logic [15:0] digit_value;
  fcbp_pkg::digit_src_t digit_src;

  assign rx_byte     = rx_i.rx_byte;
  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign in_acc      = rx_i.valid && rx_i.ready;
  assign cmd_hit     = (rx_byte >= fcbp_pkg::CmdFirst) && (rx_byte <= fcbp_pkg::CmdLast);
  assign fire        = in_acc && (phase_q == fcbp_pkg::PhCmd) && cmd_hit;

  // Head bytes: stored bytes below the count, zero elsewhere.
  for (genvar k = 0; k < fcbp_pkg::HeadBytes; k++) begin : g_head
    if (k < fcbp_pkg::PayloadBytes) begin : g_stored
      assign head[8*k +: 8] = (byte_count_q > 8'(k)) ? store_q[k] : 8'h00;
    end else begin : g_none
      assign head[8*k +: 8] = 8'h00;
    end
  end

  assign digit_src.len  = byte_count_q;
  assign digit_src.lead = head[23:0];

  fcbp_digit_conv u_digit_conv (
    .src_i         (digit_src),
    .digit_value_o (digit_value)
  );

  // Frame state machine and control bits
  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    overflow_d   = overflow_q;
    coef_d       = coef_q;
    debug_d      = debug_q;
    sleep_d      = sleep_q;
    power_d      = power_q;
    store_wr     = 1'b0;
    if (in_acc) begin
      unique case (phase_q)
        fcbp_pkg::PhHunt: begin
          phase_d = (rx_byte == fcbp_pkg::CharCr) ? fcbp_pkg::PhLf : fcbp_pkg::PhHunt;
        end
        fcbp_pkg::PhLf: begin
          if (rx_byte == fcbp_pkg::CharLf) begin
            phase_d      = fcbp_pkg::PhPayload;
            byte_count_d = 8'h00;
            overflow_d   = 1'b0;
          end else begin
            phase_d = fcbp_pkg::PhHunt;
          end
        end
        fcbp_pkg::PhPayload: begin
          if (rx_byte == fcbp_pkg::CharCr) begin
            phase_d = fcbp_pkg::PhCmd;
          end else begin
            if (byte_count_q < 8'(fcbp_pkg::PayloadBytes)) begin
              store_wr = 1'b1;
            end else begin
              overflow_d = 1'b1;
            end
            if (byte_count_q != fcbp_pkg::CountMax) begin
              byte_count_d = byte_count_q + 8'd1;
            end
          end
        end
        fcbp_pkg::PhCmd: begin
          phase_d = fcbp_pkg::PhHunt;
          if (cmd_hit) begin
            unique case (rx_byte)
              fcbp_pkg::CmdSleepClr: sleep_d = 1'b0;
              fcbp_pkg::CmdDebug:    debug_d = !debug_q;
              fcbp_pkg::CmdSleep:    sleep_d = !sleep_q;
              fcbp_pkg::CmdPower:    power_d = !power_q;
              fcbp_pkg::CmdCoef:     coef_d  = head[7:0] ^ fcbp_pkg::CharZero;
              default: ;
            endcase
          end
        end
        default: phase_d = fcbp_pkg::PhHunt;
      endcase
    end
  end

  // Result word, built from the state after the command
  always_comb begin
    res_d.command_code     = 4'(rx_byte - fcbp_pkg::CmdFirst);
    res_d.payload_len      = byte_count_q;
    res_d.payload_overflow = overflow_q;
    res_d.payload_head     = head;
    res_d.digit_value      = digit_value;
    res_d.coef_select      = coef_d;
    res_d.debug_on         = debug_d;
    res_d.sleep_on         = sleep_d;
    res_d.power_on         = power_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= fcbp_pkg::PhHunt;
      byte_count_q <= 8'h00;
      overflow_q   <= 1'b0;
      coef_q       <= 8'h00;
      debug_q      <= 1'b0;
      sleep_q      <= 1'b0;
      power_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      overflow_q   <= overflow_d;
      coef_q       <= coef_d;
      debug_q      <= debug_d;
      sleep_q      <= sleep_d;
      power_q      <= power_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload store: only positions below the count are ever shown
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[byte_count_q[fcbp_pkg::StoreIdxW-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.command_code     = res_q.command_code;
  assign res_o.payload_len      = res_q.payload_len;
  assign res_o.payload_overflow = res_q.payload_overflow;
  assign res_o.payload_head     = res_q.payload_head;
  assign res_o.digit_value      = res_q.digit_value;
  assign res_o.coef_select      = res_q.coef_select;
  assign res_o.debug_on         = res_q.debug_on;
  assign res_o.sleep_on         = res_q.sleep_on;
  assign res_o.power_on         = res_q.power_on;

  // Only a command byte can load a result
  a_no_result_outside_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q != fcbp_pkg::PhCmd) |=> !out_valid_q)
    else $error("result raised by a non-command byte");

  // LF after CR opens a clean payload
  a_lf_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == fcbp_pkg::PhLf && rx_byte == fcbp_pkg::CharLf)
    |=> (byte_count_q == 8'h00 && !overflow_q && phase_q == fcbp_pkg::PhPayload))
    else $error("frame start did not clear payload state");

  a_digits_need_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.digit_value != fcbp_pkg::BadDigit) |-> (res_q.payload_len >= 8'd3))
    else $error("digit value from a short payload");

  a_overflow_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.payload_overflow)
    |-> (res_q.payload_len > 8'(fcbp_pkg::PayloadBytes)))
    else $error("overflow flagged without excess bytes");

endmodule

`default_nettype wire
